[sv/mcdc_pkg.sv]
// Shared types and constants for the multi-channel delta counter.
package mcdc_pkg;

    localparam int unsigned NCOUNTS = 7;

    localparam int unsigned W_TOTAL = 0;
    localparam int unsigned W_HUMAN = 1;
    localparam int unsigned W_CAR   = 2;
    localparam int unsigned W_BIKE  = 3;
    localparam int unsigned W_BUS   = 4;
    localparam int unsigned W_TRUCK = 5;
    localparam int unsigned W_OTHER = 6;

    localparam logic MODE_SNAPSHOT = 1'b0;
    localparam logic MODE_PRELOAD  = 1'b1;

    typedef enum logic [2:0] {
        STAT_REF_TAKEN   = 3'd0,
        STAT_RESTART     = 3'd1,
        STAT_ACCUMULATED = 3'd2,
        STAT_UNCHANGED   = 3'd3,
        STAT_PRELOADED   = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_CALC = 1'b1
    } state_t;

endpackage

[sv/multi_channel_delta_counter.sv]
// Multi-channel delta counter: per-channel reference and accumulator memories with RMW update.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_ready    mode, channel, seven 32-bit counts
//   output   out        out_valid / out_ready  out_channel, status, seven accumulators, flag
//
// For each word, the accept edge reads the channel's reference and accumulator rows from the
// memories, and the update edge in ST_CALC updates them and loads the output register.
// in_ready is high whenever no word is being processed, even while a result waits.
// A held result stalls the update cycle until out_ready.
// Reset clears the reference flags and accumulator valid bits; no clearing pass is needed.
module multi_channel_delta_counter #(
    parameter int unsigned CHANNELS   = 16,
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [3:0]           channel,
    input  logic [31:0]          total_count,
    input  logic [31:0]          human_count,
    input  logic [31:0]          car_count,
    input  logic [31:0]          bike_count,
    input  logic [31:0]          bus_count,
    input  logic [31:0]          truck_count,
    input  logic [31:0]          other_count,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           out_channel,
    output logic [2:0]           status,
    output logic [31:0]          acc_total,
    output logic [31:0]          acc_human,
    output logic [31:0]          acc_car,
    output logic [31:0]          acc_bike,
    output logic [31:0]          acc_bus,
    output logic [31:0]          acc_truck,
    output logic [31:0]          acc_other,
    output logic                 reference_valid
);

    localparam int unsigned CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned NC      = mcdc_pkg::NCOUNTS;

    typedef logic [NC-1:0][COUNT_BITS-1:0] row_t;

    // Memories
    row_t ref_mem [CHANNELS];
    row_t acc_mem [CHANNELS];

    row_t ref_rd_reg;
    row_t acc_rd_reg;
    logic acc_vld_rd_reg;

    logic [CHANNELS-1:0] flags_reg, flags_next;
    logic [CHANNELS-1:0] acc_vld_reg, acc_vld_next;

    mcdc_pkg::state_t state_reg, state_next;

    // Held input word
    logic                mode_reg;
    logic [3:0]          channel_reg;
    row_t                cnt_reg;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [3:0]          out_channel_reg;
    mcdc_pkg::status_t   status_reg, status_next;
    row_t                out_acc_reg, out_acc_next;
    logic                ref_valid_reg, ref_valid_next;

    logic                accept;
    logic                fire;
    logic [8:0]          in_ch_wide;
    logic [8:0]          ch_wide;
    logic [CH_BITS-1:0]  rd_idx;
    logic [CH_BITS-1:0]  wr_idx;
    logic                in_range;
    logic                flag_cur;
    row_t                acc_cur;
    row_t                acc_new;
    row_t                acc_add;
    logic                down;
    logic                rise;
    logic                ref_we;
    logic                acc_we;
    logic [COUNT_BITS:0]   add_tmp [NC];
    logic [COUNT_BITS:0]   s_a, s_b, s_c;
    logic [COUNT_BITS+2:0] s_all;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == mcdc_pkg::ST_IDLE);
    assign fire       = (state_reg == mcdc_pkg::ST_CALC) && (!out_valid_reg || out_ready);
    assign in_ch_wide = {5'd0, channel};
    assign rd_idx     = in_ch_wide[CH_BITS-1:0];
    assign ch_wide    = {5'd0, channel_reg};
    assign wr_idx     = ch_wide[CH_BITS-1:0];
    assign in_range   = (ch_wide < 9'(CHANNELS));
    assign flag_cur   = in_range && flags_reg[wr_idx];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ref_rd_reg <= ref_mem[rd_idx];
            acc_rd_reg <= acc_mem[rd_idx];
        end
        if (fire && ref_we)
        begin
            ref_mem[wr_idx] <= cnt_reg;
        end
        if (fire && acc_we)
        begin
            acc_mem[wr_idx] <= acc_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_vld_rd_reg <= acc_vld_reg[rd_idx];
            mode_reg       <= mode;
            channel_reg    <= channel;
            cnt_reg[mcdc_pkg::W_TOTAL] <= total_count[COUNT_BITS-1:0];
            cnt_reg[mcdc_pkg::W_HUMAN] <= human_count[COUNT_BITS-1:0];
            cnt_reg[mcdc_pkg::W_CAR]   <= car_count[COUNT_BITS-1:0];
            cnt_reg[mcdc_pkg::W_BIKE]  <= bike_count[COUNT_BITS-1:0];
            cnt_reg[mcdc_pkg::W_BUS]   <= bus_count[COUNT_BITS-1:0];
            cnt_reg[mcdc_pkg::W_TRUCK] <= truck_count[COUNT_BITS-1:0];
            cnt_reg[mcdc_pkg::W_OTHER] <= other_count[COUNT_BITS-1:0];
        end
        if (fire)
        begin
            out_channel_reg <= channel_reg;
            status_reg      <= status_next;
            out_acc_reg     <= out_acc_next;
            ref_valid_reg   <= ref_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcdc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            acc_vld_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
            acc_vld_reg   <= acc_vld_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            acc_cur[k] = acc_vld_rd_reg ? acc_rd_reg[k] : '0;
        end

        down = 1'b0;
        for (int k = 0; k < NC; k++)
        begin
            if (cnt_reg[k] < ref_rd_reg[k])
            begin
                down = 1'b1;
            end
        end
        rise = cnt_reg[mcdc_pkg::W_TOTAL] > ref_rd_reg[mcdc_pkg::W_TOTAL];

        for (int k = 0; k < NC; k++)
        begin
            add_tmp[k] = {1'b0, acc_cur[k]} + {1'b0, COUNT_BITS'(cnt_reg[k] - ref_rd_reg[k])};
            acc_add[k] = add_tmp[k][COUNT_BITS] ? '1 : add_tmp[k][COUNT_BITS-1:0];
        end

        s_a   = {1'b0, cnt_reg[mcdc_pkg::W_HUMAN]} + {1'b0, cnt_reg[mcdc_pkg::W_CAR]};
        s_b   = {1'b0, cnt_reg[mcdc_pkg::W_BIKE]}  + {1'b0, cnt_reg[mcdc_pkg::W_BUS]};
        s_c   = {1'b0, cnt_reg[mcdc_pkg::W_TRUCK]} + {1'b0, cnt_reg[mcdc_pkg::W_OTHER]};
        s_all = {2'b00, s_a} + {2'b00, s_b} + {2'b00, s_c};

        status_next  = mcdc_pkg::STAT_UNCHANGED;
        acc_new      = acc_cur;
        ref_we       = 1'b0;
        acc_we       = 1'b0;
        flags_next   = flags_reg;
        acc_vld_next = acc_vld_reg;
        ref_valid_next = flag_cur;

        if (in_range)
        begin
            if (mode_reg == mcdc_pkg::MODE_PRELOAD)
            begin
                acc_new = cnt_reg;
                acc_new[mcdc_pkg::W_TOTAL] = (s_all[COUNT_BITS+2:COUNT_BITS] != 3'd0) ?
                                             '1 : s_all[COUNT_BITS-1:0];
                acc_we         = 1'b1;
                ref_valid_next = 1'b0;
                status_next    = mcdc_pkg::STAT_PRELOADED;
            end
            else if (!flag_cur)
            begin
                ref_we         = 1'b1;
                ref_valid_next = 1'b1;
                status_next    = mcdc_pkg::STAT_REF_TAKEN;
            end
            else if (down)
            begin
                ref_we      = 1'b1;
                status_next = mcdc_pkg::STAT_RESTART;
            end
            else if (rise)
            begin
                acc_new     = acc_add;
                acc_we      = 1'b1;
                ref_we      = 1'b1;
                status_next = mcdc_pkg::STAT_ACCUMULATED;
            end
        end

        if (fire && in_range)
        begin
            flags_next[wr_idx] = ref_valid_next;
            if (acc_we)
            begin
                acc_vld_next[wr_idx] = 1'b1;
            end
        end

        out_acc_next = in_range ? acc_new : '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            mcdc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mcdc_pkg::ST_CALC;
                end
            end
            mcdc_pkg::ST_CALC:
            begin
                if (fire)
                begin
                    state_next     = mcdc_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = mcdc_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign out_channel     = out_channel_reg;
    assign status          = status_reg;
    assign acc_total       = 32'(out_acc_reg[mcdc_pkg::W_TOTAL]);
    assign acc_human       = 32'(out_acc_reg[mcdc_pkg::W_HUMAN]);
    assign acc_car         = 32'(out_acc_reg[mcdc_pkg::W_CAR]);
    assign acc_bike        = 32'(out_acc_reg[mcdc_pkg::W_BIKE]);
    assign acc_bus         = 32'(out_acc_reg[mcdc_pkg::W_BUS]);
    assign acc_truck       = 32'(out_acc_reg[mcdc_pkg::W_TRUCK]);
    assign acc_other       = 32'(out_acc_reg[mcdc_pkg::W_OTHER]);
    assign reference_valid = ref_valid_reg;

`ifndef SYNTHESIS
    a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == mcdc_pkg::ST_CALC))
        else $error("accepted word did not enter update cycle");

    a_result_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == mcdc_pkg::ST_CALC))
        else $error("result appeared without an update cycle");

    a_preload_clears_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status_reg == mcdc_pkg::STAT_PRELOADED)) |-> !reference_valid)
        else $error("preload result shows a reference");

    a_update_has_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((status_reg == mcdc_pkg::STAT_ACCUMULATED) ||
                       (status_reg == mcdc_pkg::STAT_RESTART) ||
                       (status_reg == mcdc_pkg::STAT_REF_TAKEN))) |-> reference_valid)
        else $error("reference update without reference flag");
`endif

endmodule

[tb/tb_multi_channel_delta_counter.sv]
// Testbench for the multi-channel delta counter: queued driver, checking monitor, predictor.
module tb_multi_channel_delta_counter;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                                mode;
        logic [3:0]                          channel;
        logic [mcdc_pkg::NCOUNTS-1:0][31:0]  cnt;
    } count_word_t;

    typedef struct packed {
        logic [3:0]                          channel;
        mcdc_pkg::status_t                   status;
        logic [mcdc_pkg::NCOUNTS-1:0][31:0]  acc;
        logic                                ref_valid;
    } tally_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = mcdc_pkg::MODE_SNAPSHOT;
    logic [3:0]  channel = '0;
    logic [31:0] total_count = '0;
    logic [31:0] human_count = '0;
    logic [31:0] car_count = '0;
    logic [31:0] bike_count = '0;
    logic [31:0] bus_count = '0;
    logic [31:0] truck_count = '0;
    logic [31:0] other_count = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  out_channel;
    logic [2:0]  status;
    logic [31:0] acc_total;
    logic [31:0] acc_human;
    logic [31:0] acc_car;
    logic [31:0] acc_bike;
    logic [31:0] acc_bus;
    logic [31:0] acc_truck;
    logic [31:0] acc_other;
    logic        reference_valid;

    count_word_t pending_words [$];
    tally_t      predicted_tallies [$];
    count_word_t driven_word = '0;

    logic [mcdc_pkg::NCOUNTS-1:0][31:0] snap_ref [16];
    logic [mcdc_pkg::NCOUNTS-1:0][31:0] acc_sum [16] = '{default: '0};
    logic [15:0]                        has_ref = '0;

    logic [mcdc_pkg::NCOUNTS-1:0][31:0] gen_last [16];
    logic [15:0]                        gen_started = '0;

    int unsigned words_total = 0;
    int unsigned words_accepted = 0;
    int unsigned tallies_seen = 0;
    int unsigned errors = 0;

    multi_channel_delta_counter dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .channel         (channel),
        .total_count     (total_count),
        .human_count     (human_count),
        .car_count       (car_count),
        .bike_count      (bike_count),
        .bus_count       (bus_count),
        .truck_count     (truck_count),
        .other_count     (other_count),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_channel     (out_channel),
        .status          (status),
        .acc_total       (acc_total),
        .acc_human       (acc_human),
        .acc_car         (acc_car),
        .acc_bike        (acc_bike),
        .acc_bus         (acc_bus),
        .acc_truck       (acc_truck),
        .acc_other       (acc_other),
        .reference_valid (reference_valid)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic tally_t predict_tally(input count_word_t w);
        tally_t t;
        logic   down;
        int     c;
        c = w.channel;
        t.channel = w.channel;
        if (w.mode == mcdc_pkg::MODE_PRELOAD)
        begin
            acc_sum[c][mcdc_pkg::W_TOTAL] = '0;
            for (int k = 1; k < mcdc_pkg::NCOUNTS; k++)
            begin
                acc_sum[c][k] = w.cnt[k];
                acc_sum[c][mcdc_pkg::W_TOTAL] = clamp_add(acc_sum[c][mcdc_pkg::W_TOTAL],
                                                          w.cnt[k]);
            end
            has_ref[c] = 1'b0;
            t.status = mcdc_pkg::STAT_PRELOADED;
        end
        else if (!has_ref[c])
        begin
            snap_ref[c] = w.cnt;
            has_ref[c] = 1'b1;
            t.status = mcdc_pkg::STAT_REF_TAKEN;
        end
        else
        begin
            down = 1'b0;
            for (int k = 0; k < mcdc_pkg::NCOUNTS; k++)
            begin
                if (w.cnt[k] < snap_ref[c][k])
                begin
                    down = 1'b1;
                end
            end
            if (down)
            begin
                snap_ref[c] = w.cnt;
                t.status = mcdc_pkg::STAT_RESTART;
            end
            else if (w.cnt[mcdc_pkg::W_TOTAL] > snap_ref[c][mcdc_pkg::W_TOTAL])
            begin
                for (int k = 0; k < mcdc_pkg::NCOUNTS; k++)
                begin
                    acc_sum[c][k] = clamp_add(acc_sum[c][k], w.cnt[k] - snap_ref[c][k]);
                end
                snap_ref[c] = w.cnt;
                t.status = mcdc_pkg::STAT_ACCUMULATED;
            end
            else
            begin
                t.status = mcdc_pkg::STAT_UNCHANGED;
            end
        end
        t.acc = acc_sum[c];
        t.ref_valid = has_ref[c];
        return t;
    endfunction

    task automatic queue_word(input logic m, input logic [3:0] ch,
                              input logic [mcdc_pkg::NCOUNTS-1:0][31:0] v);
        count_word_t w;
        w.mode = m;
        w.channel = ch;
        w.cnt = v;
        pending_words.push_back(w);
        if (m == mcdc_pkg::MODE_PRELOAD)
        begin
            gen_started[ch] = 1'b0;
        end
        else
        begin
            gen_last[ch] = v;
            gen_started[ch] = 1'b1;
        end
    endtask

    function automatic logic [31:0] spread_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1000);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic build_directed();
        logic [mcdc_pkg::NCOUNTS-1:0][31:0] v;
        v = '0;
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd0, v);
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd0, v);
        v[mcdc_pkg::W_HUMAN] = 32'd5;
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd0, v);
        v[mcdc_pkg::W_TOTAL] = 32'd10;
        for (int k = 1; k < mcdc_pkg::NCOUNTS; k++)
        begin
            v[k] = v[k] + k;
        end
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd0, v);
        v[mcdc_pkg::W_CAR] = v[mcdc_pkg::W_CAR] - 1;
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd0, v);
        for (int k = 0; k < mcdc_pkg::NCOUNTS; k++)
        begin
            v[k] = v[k] + 3 * k + 1;
        end
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd0, v);

        v = '1;
        queue_word(mcdc_pkg::MODE_PRELOAD, 4'd1, v);
        v = '0;
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd1, v);
        for (int k = 0; k < mcdc_pkg::NCOUNTS; k++)
        begin
            v[k] = 32'd100 + k;
        end
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd1, v);

        v = '1;
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd2, v);
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd2, v);
        v[mcdc_pkg::W_TOTAL] = '0;
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd2, v);
        v = '0;
        v[mcdc_pkg::W_TOTAL] = '1;
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd2, v);

        v = '0;
        v[mcdc_pkg::W_TOTAL] = '1;
        queue_word(mcdc_pkg::MODE_PRELOAD, 4'd15, v);
        for (int k = 0; k < mcdc_pkg::NCOUNTS; k++)
        begin
            v[k] = 32'h8000_0000 >> k;
        end
        queue_word(mcdc_pkg::MODE_PRELOAD, 4'd15, v);
        v = '0;
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd15, v);
        v = '1;
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd15, v);

        for (int k = 0; k < mcdc_pkg::NCOUNTS; k++)
        begin
            v[k] = 32'hFFFF_FFF0;
        end
        queue_word(mcdc_pkg::MODE_PRELOAD, 4'd3, v);
        v = '0;
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd3, v);
        for (int k = 0; k < mcdc_pkg::NCOUNTS; k++)
        begin
            v[k] = 32'h20;
        end
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd3, v);
        v = '1;
        queue_word(mcdc_pkg::MODE_SNAPSHOT, 4'd3, v);
    endtask

    task automatic build_random(input int unsigned n);
        logic [mcdc_pkg::NCOUNTS-1:0][31:0] v;
        logic [3:0]                         ch;
        int unsigned                        r;
        int                                 k;
        for (int unsigned i = 0; i < n; i++)
        begin
            ch = $urandom_range(0, 15);
            r = $urandom_range(0, 99);
            v = gen_last[ch];
            if (r < 8)
            begin
                for (k = 0; k < mcdc_pkg::NCOUNTS; k++)
                begin
                    v[k] = spread_value();
                end
                queue_word(mcdc_pkg::MODE_PRELOAD, ch, v);
            end
            else if (r < 14 || !gen_started[ch])
            begin
                for (k = 0; k < mcdc_pkg::NCOUNTS; k++)
                begin
                    v[k] = (r < 14) ? $urandom : spread_value();
                end
                queue_word(mcdc_pkg::MODE_SNAPSHOT, ch, v);
            end
            else if (r < 22)
            begin
                k = $urandom_range(0, mcdc_pkg::NCOUNTS - 1);
                if (v[k] != 0)
                begin
                    v[k] = v[k] - $urandom_range(1, v[k] > 100 ? 100 : v[k]);
                end
                else
                begin
                    v[k] = $urandom;
                end
                queue_word(mcdc_pkg::MODE_SNAPSHOT, ch, v);
            end
            else if (r < 30)
            begin
                for (k = 1; k < mcdc_pkg::NCOUNTS; k++)
                begin
                    v[k] = v[k] + $urandom_range(0, 3);
                end
                queue_word(mcdc_pkg::MODE_SNAPSHOT, ch, v);
            end
            else
            begin
                v[mcdc_pkg::W_TOTAL] = v[mcdc_pkg::W_TOTAL] + $urandom_range(1, 50);
                for (k = 1; k < mcdc_pkg::NCOUNTS; k++)
                begin
                    v[k] = v[k] + $urandom_range(0, 10);
                end
                queue_word(mcdc_pkg::MODE_SNAPSHOT, ch, v);
            end
        end
    endtask

    // Driver: hold the word until accepted, then advance to the next queued one.
    always @(posedge clk or negedge rst_n)
    begin
        count_word_t w;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            mode        <= mcdc_pkg::MODE_SNAPSHOT;
            channel     <= '0;
            total_count <= '0;
            human_count <= '0;
            car_count   <= '0;
            bike_count  <= '0;
            bus_count   <= '0;
            truck_count <= '0;
            other_count <= '0;
            driven_word <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted_tallies.push_back(predict_tally(driven_word));
                words_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() > 0 &&
                    ((words_accepted >= 500 && words_accepted < 800) ||
                     $urandom_range(0, 99) >= 29))
                begin
                    w = pending_words.pop_front();
                    in_valid    <= 1'b1;
                    mode        <= w.mode;
                    channel     <= w.channel;
                    total_count <= w.cnt[mcdc_pkg::W_TOTAL];
                    human_count <= w.cnt[mcdc_pkg::W_HUMAN];
                    car_count   <= w.cnt[mcdc_pkg::W_CAR];
                    bike_count  <= w.cnt[mcdc_pkg::W_BIKE];
                    bus_count   <= w.cnt[mcdc_pkg::W_BUS];
                    truck_count <= w.cnt[mcdc_pkg::W_TRUCK];
                    other_count <= w.cnt[mcdc_pkg::W_OTHER];
                    driven_word <= w;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each tally taken at the output against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        tally_t got;
        tally_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= (tallies_seen >= 500 && tallies_seen < 800) ||
                         ($urandom_range(0, 99) >= 29);
            if (out_valid && out_ready)
            begin
                got.channel                = out_channel;
                got.status                 = mcdc_pkg::status_t'(status);
                got.acc[mcdc_pkg::W_TOTAL] = acc_total;
                got.acc[mcdc_pkg::W_HUMAN] = acc_human;
                got.acc[mcdc_pkg::W_CAR]   = acc_car;
                got.acc[mcdc_pkg::W_BIKE]  = acc_bike;
                got.acc[mcdc_pkg::W_BUS]   = acc_bus;
                got.acc[mcdc_pkg::W_TRUCK] = acc_truck;
                got.acc[mcdc_pkg::W_OTHER] = acc_other;
                got.ref_valid              = reference_valid;
                tallies_seen++;
                if (predicted_tallies.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected word: ch=%0d st=%0d", got.channel, status);
                    end
                end
                else
                begin
                    want = predicted_tallies.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch #%0d expected ch=%0d st=%0d ref=%0b acc=%h",
                                     tallies_seen, want.channel, want.status,
                                     want.ref_valid, want.acc);
                            $display("mismatch #%0d actual   ch=%0d st=%0d ref=%0b acc=%h",
                                     tallies_seen, got.channel, status,
                                     got.ref_valid, got.acc);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        build_directed();
        build_random(1400);
        words_total = pending_words.size();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (words_accepted < words_total)
        begin
            @(posedge clk);
        end
        while (predicted_tallies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && predicted_tallies.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
